[rtl/core/segment_occlusion_by_boxes_unit_defines.svh]
// Assertion macros used by the checker file of the segment occlusion unit.
// Needs clk and rst_n in scope where a macro is used.
`ifndef SEGMENT_OCCLUSION_BY_BOXES_UNIT_DEFINES_SVH
`define SEGMENT_OCCLUSION_BY_BOXES_UNIT_DEFINES_SVH

// same-cycle implication
`define SOOB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("soob assertion failed");

// next-cycle implication
`define SOOB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("soob assertion failed");

`endif

[rtl/core/soob_pkg.sv]
// Types and constants of the segment occlusion unit.
// No dependencies; used by the edge test unit and the top level.
`default_nettype none

package soob_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int CORNERS    = 4;
  localparam int CFG_BITS   = 7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } corner_t;

  // segment a-b against edge c-d
  typedef struct packed {
    logic    valid;
    corner_t a;
    corner_t b;
    corner_t c;
    corner_t d;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic crossed;
    logic pending;
  } edge_res_t;

endpackage

`default_nettype wire

[rtl/core/soob_edge_unit.sv]
// Pipelined segment/edge straddle test: differences, products, sign compare.
// Depends on soob_pkg.
`default_nettype none

module soob_edge_unit
  import soob_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire edge_req_t req,
  output edge_res_t      res
);

  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  // stage A: differences
  logic  va_r;
  diff_t abx_r, aby_r, cdx_r, cdy_r;
  diff_t cax_r, cay_r, dax_r, day_r;
  diff_t acx_r, acy_r, bcx_r, bcy_r;

  // stage B: products
  logic  vb_r;
  prod_t p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r, p4a_r, p4b_r;

  // stage C: result
  logic  vc_r;
  logic  crossed_r;

  cross_t c1, c2, c3, c4;
  logic   side_ab, side_cd;

  always_ff @(posedge clk) begin
    abx_r <= DIFF_BITS'(req.b.x) - DIFF_BITS'(req.a.x);
    aby_r <= DIFF_BITS'(req.b.y) - DIFF_BITS'(req.a.y);
    cdx_r <= DIFF_BITS'(req.d.x) - DIFF_BITS'(req.c.x);
    cdy_r <= DIFF_BITS'(req.d.y) - DIFF_BITS'(req.c.y);
    cax_r <= DIFF_BITS'(req.c.x) - DIFF_BITS'(req.a.x);
    cay_r <= DIFF_BITS'(req.c.y) - DIFF_BITS'(req.a.y);
    dax_r <= DIFF_BITS'(req.d.x) - DIFF_BITS'(req.a.x);
    day_r <= DIFF_BITS'(req.d.y) - DIFF_BITS'(req.a.y);
    acx_r <= DIFF_BITS'(req.a.x) - DIFF_BITS'(req.c.x);
    acy_r <= DIFF_BITS'(req.a.y) - DIFF_BITS'(req.c.y);
    bcx_r <= DIFF_BITS'(req.b.x) - DIFF_BITS'(req.c.x);
    bcy_r <= DIFF_BITS'(req.b.y) - DIFF_BITS'(req.c.y);

    p1a_r <= PROD_BITS'(abx_r) * PROD_BITS'(cay_r);
    p1b_r <= PROD_BITS'(aby_r) * PROD_BITS'(cax_r);
    p2a_r <= PROD_BITS'(abx_r) * PROD_BITS'(day_r);
    p2b_r <= PROD_BITS'(aby_r) * PROD_BITS'(dax_r);
    p3a_r <= PROD_BITS'(cdx_r) * PROD_BITS'(acy_r);
    p3b_r <= PROD_BITS'(cdy_r) * PROD_BITS'(acx_r);
    p4a_r <= PROD_BITS'(cdx_r) * PROD_BITS'(bcy_r);
    p4b_r <= PROD_BITS'(cdy_r) * PROD_BITS'(bcx_r);

    crossed_r <= !side_ab && !side_cd;
  end

  always_comb begin
    c1 = CROSS_BITS'(p1a_r) - CROSS_BITS'(p1b_r);
    c2 = CROSS_BITS'(p2a_r) - CROSS_BITS'(p2b_r);
    c3 = CROSS_BITS'(p3a_r) - CROSS_BITS'(p3b_r);
    c4 = CROSS_BITS'(p4a_r) - CROSS_BITS'(p4b_r);
    // both ends strictly on the same side
    side_ab = (c1 != '0) && (c2 != '0) && (c1[CROSS_BITS-1] == c2[CROSS_BITS-1]);
    side_cd = (c3 != '0) && (c4 != '0) && (c3[CROSS_BITS-1] == c4[CROSS_BITS-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= req.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  assign res.valid   = vc_r;
  assign res.crossed = crossed_r;
  assign res.pending = va_r | vb_r;

endmodule

`default_nettype wire

[rtl/core/segment_occlusion_by_boxes_unit.sv]
// Segment occlusion unit: corner store, query sequencer and result register.
// Depends on soob_pkg and soob_edge_unit.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_tvalid/in_tready   | in_tuser: operation; in_tdata: corner or segment
//  out     | out | out_tvalid/out_tready | out_tdata: clear_path
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_data: box_count
//
// A corner write leaves the unit ready for the next request. For a query over N boxes,
// the single-port corner store is read once per cycle, five reads per box
// (corner 0 again closes the last edge), and the edge unit adds three stages.
// Reset (synchronous, rst_n low) clears control state; the corner store is not cleared.
// A finished result waits in the output register; the next request is taken meanwhile,
// but a query only completes once that register is free.
`default_nettype none

module segment_occlusion_by_boxes_unit
  import soob_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // [5:0] box_index, [7:6] corner_index, [23:8] corner_x, [39:24] corner_y,
  // [55:40] start_x, [71:56] start_y, [87:72] end_x, [103:88] end_y
  input  wire logic [103:0]        in_tdata,
  // [0] operation
  input  wire logic [0:0]          in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [0] clear_path, [7:1] zero
  output logic [7:0]               out_tdata,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  localparam int BPW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int AW    = BPW + 2;
  localparam int CW    = $clog2(MAX_BOXES + 1);
  localparam int DEPTH = CORNERS * MAX_BOXES;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [2:0] STEP_LAST = 3'd4;

  // request fields
  logic [5:0] f_box;
  logic [1:0] f_corner;
  corner_t    f_corner_val, f_start, f_end;

  assign f_box          = in_tdata[5:0];
  assign f_corner       = in_tdata[7:6];
  assign f_corner_val.x = in_tdata[23:8];
  assign f_corner_val.y = in_tdata[39:24];
  assign f_start.x      = in_tdata[55:40];
  assign f_start.y      = in_tdata[71:56];
  assign f_end.x        = in_tdata[87:72];
  assign f_end.y        = in_tdata[103:88];

  logic [1:0]          state_r, state_nxt;
  logic [CFG_BITS-1:0] box_count_r;
  logic [CW-1:0]       nboxes_r, nboxes_nxt;
  logic [BPW-1:0]      box_r, box_nxt;
  logic [2:0]          step_r, step_nxt;
  logic                clear_acc_r, clear_acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_clear_r, out_clear_nxt;
  corner_t             qa_r, qb_r;

  corner_t             mem [DEPTH];
  corner_t             rd_corner_r, prev_corner_r;
  logic                mem_v_r, mem_edge_r;

  logic                in_acc, wr_en, rd_en, last_box, drained;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [CW-1:0]       clamped;
  edge_req_t           ereq;
  edge_res_t           eres;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  assign wr_en   = in_acc && (in_tuser[0] == OP_WRITE) && (32'(f_box) < MAX_BOXES);
  assign wr_addr = {BPW'(f_box), f_corner};
  assign rd_en   = (state_r == ST_RUN);
  assign rd_addr = {box_r, step_r[1:0]};

  assign clamped  = (32'(box_count_r) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(box_count_r);
  assign last_box = ((CW + 1)'(box_r) + (CW + 1)'(1)) == (CW + 1)'(nboxes_r);
  assign drained  = !mem_v_r && !eres.pending && !eres.valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= f_corner_val;
    end
    if (rd_en) begin
      rd_corner_r <= mem[rd_addr];
    end
    if (mem_v_r) begin
      prev_corner_r <= rd_corner_r;
    end
    if (in_acc && (in_tuser[0] == OP_QUERY)) begin
      qa_r <= f_start;
      qb_r <= f_end;
    end
  end

  assign ereq.valid = mem_v_r && mem_edge_r;
  assign ereq.a     = qa_r;
  assign ereq.b     = qb_r;
  assign ereq.c     = prev_corner_r;
  assign ereq.d     = rd_corner_r;

  soob_edge_unit u_edge (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ereq),
    .res  (eres)
  );

  always_comb begin
    state_nxt     = state_r;
    nboxes_nxt    = nboxes_r;
    box_nxt       = box_r;
    step_nxt      = step_r;
    clear_acc_nxt = clear_acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_clear_nxt = out_clear_r;

    if (eres.valid && eres.crossed) begin
      clear_acc_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser[0] == OP_QUERY)) begin
          nboxes_nxt    = clamped;
          box_nxt       = '0;
          step_nxt      = '0;
          clear_acc_nxt = 1'b1;
          state_nxt     = (clamped == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_LAST) begin
          step_nxt = '0;
          if (last_box) begin
            state_nxt = ST_DRAIN;
          end else begin
            box_nxt = box_r + BPW'(1);
          end
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (drained && (!out_valid_r || out_tready)) begin
          out_valid_nxt = 1'b1;
          out_clear_nxt = clear_acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      box_count_r <= '0;
      out_valid_r <= 1'b0;
      mem_v_r     <= 1'b0;
      mem_edge_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mem_v_r     <= rd_en;
      mem_edge_r  <= rd_en && (step_r != '0);
      if (cfg_valid && cfg_ready) begin
        box_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    nboxes_r    <= nboxes_nxt;
    box_r       <= box_nxt;
    step_r      <= step_nxt;
    clear_acc_r <= clear_acc_nxt;
    out_clear_r <= out_clear_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_clear_r};

endmodule

`default_nettype wire

[rtl/core/soob_checker.sv]
// Port-level checks of the segment occlusion unit, bound to the top level.
// Depends on the assertion macros in segment_occlusion_by_boxes_unit_defines.svh.
`default_nettype none

`include "segment_occlusion_by_boxes_unit_defines.svh"

module soob_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [103:0] in_tdata,
  input wire logic [0:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [7:0]   out_tdata,
  input wire logic         cfg_valid,
  input wire logic         cfg_ready,
  input wire logic [6:0]   cfg_data
);

  logic query_acc, write_acc;

  assign query_acc = in_tvalid && in_tready && in_tuser[0];
  assign write_acc = in_tvalid && in_tready && !in_tuser[0];

  // stalled result holds
  `SOOB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // a query occupies the sequencer for at least the next cycle
  `SOOB_ASSERT_NEXT(a_query_busy, query_acc, !in_tready)
  // a corner write leaves the unit ready in the following cycle
  `SOOB_ASSERT_NEXT(a_write_single, write_acc, in_tready)
  // padding bits of the result stay zero, and cfg_ready is high, while a result is valid
  `SOOB_ASSERT_NOW(a_out_pad, out_tvalid, out_tdata[7:1] == 7'd0 && cfg_ready)

  logic unused_ok;
  assign unused_ok = ^{in_tdata, cfg_valid, cfg_data};

endmodule

bind segment_occlusion_by_boxes_unit soob_checker u_soob_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

`default_nettype wire
